[hw/rtl/ifdp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ifdp_pkg
// Shared types, constants and saturating Q32.32 helpers for the implicit
// finite-difference option pricer.
// ----------------------------------------------------------------------------
package ifdp_pkg;

   localparam int GRID_N = 100;
   localparam int DEPTH  = GRID_N + 1;
   localparam int IDX_W  = $clog2(DEPTH);

   typedef logic signed [63:0] q_type;

   localparam q_type Q_ONE  = 64'sh0000_0001_0000_0000;
   localparam q_type Q_HALF = 64'sh0000_0000_8000_0000;
   localparam q_type Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam q_type Q_MIN  = 64'sh8000_0000_0000_0000;
   localparam q_type Q_N    = q_type'({32'(GRID_N), 32'h0});

   // shared unit operations
   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_DIVQ = 2'd1;
   localparam logic [1:0] OP_DIVI = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEPS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEPS     = 1'd1;

   typedef struct packed {
      logic [31:0]        spot_price;
      logic [31:0]        strike_price;
      logic [31:0]        expiry_years;
      logic [31:0]        volatility;
      logic signed [31:0] interest_rate;
      logic signed [31:0] dividend_yield;
      logic               option_kind;
   } req_type;

   typedef struct packed {
      logic [31:0] option_value;
      logic        out_of_range;
   } rsp_type;

   typedef struct packed {
      logic       go;
      logic [1:0] op;
      q_type      a;
      q_type      b;
   } arith_req_type;

   typedef struct packed {
      logic  done;
      q_type result;
   } arith_rsp_type;

   function automatic q_type qadd(q_type a, q_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

   function automatic q_type qsub(q_type a, q_type b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

   function automatic q_type make_signed(logic neg, logic [63:0] mag);
      if (neg) return mag[63] ? Q_MIN : q_type'(~mag + 64'd1);
      return mag[63] ? Q_MAX : q_type'(mag);
   endfunction

   // Q32.32 to unsigned Q16.16, round half up, clamp
   function automatic logic [31:0] to_output(q_type v);
      logic [48:0] r;
      r = {1'b0, v[63:16]} + 49'(v[15]);
      if (v <= 0) return 32'h0;
      return (r[48:32] != 17'h0) ? 32'hFFFF_FFFF : r[31:0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/implicit_fd_option_pricer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// implicit_fd_option_pricer
// One node update is three multiplies through the single shared arithmetic
//   unit, and the interior coefficient rows dominate the setup.
// Throughput: one transaction at a time; busy is high until the result strobe.
// Reset: synchronous; control returns to idle, registers take 2000 / 999.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module implicit_fd_option_pricer
   import ifdp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   localparam logic [5:0] S_IDLE = 6'd0;
   localparam logic [5:0] S_WAIT = 6'd1;
   localparam logic [5:0] S_DS   = 6'd2;
   localparam logic [5:0] S_DT   = 6'd3;
   localparam logic [5:0] S_DTR  = 6'd4;
   localparam logic [5:0] S_VAR  = 6'd5;
   localparam logic [5:0] S_VARR = 6'd6;
   localparam logic [5:0] S_PISS = 6'd7;
   localparam logic [5:0] S_PWR  = 6'd8;
   localparam logic [5:0] S_C0   = 6'd9;
   localparam logic [5:0] S_C0B  = 6'd10;
   localparam logic [5:0] S_C0W  = 6'd11;
   localparam logic [5:0] S_CJJ  = 6'd12;
   localparam logic [5:0] S_CV   = 6'd13;
   localparam logic [5:0] S_CJD  = 6'd14;
   localparam logic [5:0] S_CA   = 6'd15;
   localparam logic [5:0] S_CA2  = 6'd16;
   localparam logic [5:0] S_CA3  = 6'd17;
   localparam logic [5:0] S_CB2  = 6'd18;
   localparam logic [5:0] S_CB3  = 6'd19;
   localparam logic [5:0] S_CC2  = 6'd20;
   localparam logic [5:0] S_CC3  = 6'd21;
   localparam logic [5:0] S_N0   = 6'd22;
   localparam logic [5:0] S_NA   = 6'd23;
   localparam logic [5:0] S_NB   = 6'd24;
   localparam logic [5:0] S_NC   = 6'd25;
   localparam logic [5:0] S_ND   = 6'd26;
   localparam logic [5:0] S_STEP = 6'd27;
   localparam logic [5:0] S_GF   = 6'd28;
   localparam logic [5:0] S_GM1  = 6'd29;
   localparam logic [5:0] S_GM2  = 6'd30;
   localparam logic [5:0] S_GM3  = 6'd31;
   localparam logic [5:0] S_GW   = 6'd32;
   localparam logic [5:0] S_KF   = 6'd33;
   localparam logic [5:0] S_KW   = 6'd34;
   localparam logic [5:0] S_FTOP = 6'd35;
   localparam logic [5:0] S_FT2  = 6'd36;
   localparam logic [5:0] S_FIDX = 6'd37;
   localparam logic [5:0] S_FREM = 6'd38;
   localparam logic [5:0] S_FLO  = 6'd39;
   localparam logic [5:0] S_FHW  = 6'd40;
   localparam logic [5:0] S_FHI  = 6'd41;
   localparam logic [5:0] S_FSUM = 6'd42;
   localparam logic [5:0] S_FRD  = 6'd43;
   localparam logic [5:0] S_FRD2 = 6'd44;

   localparam logic [IDX_W-1:0] J_LAST = IDX_W'(GRID_N);
   localparam logic [IDX_W-1:0] J_PEN  = IDX_W'(GRID_N - 1);

   // ceil(2^37 / 25): exact floor division by 25 for any 32-bit dividend
   localparam logic [32:0] RECIP_25 = 33'd5497558139;

   logic [5:0]       st_ff, st_in;
   logic [5:0]       ret_ff, ret_in;
   logic             go_ff, go_in;
   logic [1:0]       op_ff, op_in;
   q_type            a_ff, a_in;
   q_type            b_ff, b_in;
   logic [15:0]      ts_ff, ts_in;
   logic [11:0]      swc_ff, swc_in;
   q_type            spot_ff, spot_in;
   q_type            strike_ff, strike_in;
   q_type            expiry_ff, expiry_in;
   q_type            vol_ff, vol_in;
   q_type            rate_ff, rate_in;
   q_type            yld_ff, yld_in;
   logic             put_ff, put_in;
   q_type            ds_ff, ds_in;
   q_type            dt_ff, dt_in;
   q_type            drift_ff, drift_in;
   q_type            var_ff, var_in;
   q_type            vjj_ff, vjj_in;
   q_type            jd_ff, jd_in;
   q_type            t_ff, t_in;
   q_type            prev_ff, prev_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [15:0]      step_ff, step_in;
   logic [11:0]      sweep_ff, sweep_in;
   logic             flag_ff, flag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // issue request to the shared unit
   logic             iss;
   logic [1:0]       iss_op;
   q_type            iss_a, iss_b;
   logic [5:0]       iss_ret;

   arith_req_type    ureq;
   arith_rsp_type    ursp;
   q_type            res;
   q_type            jq;
   q_type            pay;

   // grid spacing: 2K/100 in Q32.32 is K * 2^15 / 25 with K the Q16.16 strike
   logic [64:0]      ds_prod;
   logic [4:0]       k_rem;

   // coefficient and solution stores
   q_type node_mem [0:GRID_N];
   q_type rhs_mem  [0:GRID_N];
   q_type sub_mem  [0:GRID_N];
   q_type sup_mem  [0:GRID_N];
   q_type inv_mem  [0:GRID_N];
   q_type node_q, rhs_q, sub_q, sup_q, inv_q;
   logic [IDX_W-1:0] node_ra;
   logic  node_we, rhs_we, sub_we, sup_we, inv_we;
   q_type node_wd, rhs_wd, sub_wd, sup_wd, inv_wd;

   // floor(r * 2^15 / 25) for a remainder r below 25
   function automatic logic [14:0] frac_25(logic [4:0] r);
      case (r)
         5'd1:    return 15'd1310;
         5'd2:    return 15'd2621;
         5'd3:    return 15'd3932;
         5'd4:    return 15'd5242;
         5'd5:    return 15'd6553;
         5'd6:    return 15'd7864;
         5'd7:    return 15'd9175;
         5'd8:    return 15'd10485;
         5'd9:    return 15'd11796;
         5'd10:   return 15'd13107;
         5'd11:   return 15'd14417;
         5'd12:   return 15'd15728;
         5'd13:   return 15'd17039;
         5'd14:   return 15'd18350;
         5'd15:   return 15'd19660;
         5'd16:   return 15'd20971;
         5'd17:   return 15'd22282;
         5'd18:   return 15'd23592;
         5'd19:   return 15'd24903;
         5'd20:   return 15'd26214;
         5'd21:   return 15'd27525;
         5'd22:   return 15'd28835;
         5'd23:   return 15'd30146;
         5'd24:   return 15'd31457;
         default: return 15'd0;
      endcase
   endfunction

   assign ureq.go = go_ff;
   assign ureq.op = op_ff;
   assign ureq.a  = a_ff;
   assign ureq.b  = b_ff;
   assign res     = ursp.result;
   assign jq      = q_type'({{(32-IDX_W){1'b0}}, j_ff, 32'h0});

   assign ds_prod = {33'h0, strike_ff[47:16]} * {32'h0, RECIP_25};
   assign k_rem   = 5'(strike_ff[47:16] - {4'h0, ds_ff[27:0]} * 32'd25);

   assign busy      = (st_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // copy reads node j, Gauss-Seidel reads the neighbour above
   assign node_ra = (st_ff == S_KF || st_ff == S_KW) ? j_ff :
                    ((j_ff == J_LAST) ? j_ff : IDX_W'(j_ff + 1'b1));

   ifdp_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (ureq),
      .rsp   (ursp)
   );

   always_comb begin
      st_in        = st_ff;
      ret_in       = ret_ff;
      go_in        = 1'b0;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ts_in        = ts_ff;
      swc_in       = swc_ff;
      spot_in      = spot_ff;
      strike_in    = strike_ff;
      expiry_in    = expiry_ff;
      vol_in       = vol_ff;
      rate_in      = rate_ff;
      yld_in       = yld_ff;
      put_in       = put_ff;
      ds_in        = ds_ff;
      dt_in        = dt_ff;
      drift_in     = drift_ff;
      var_in       = var_ff;
      vjj_in       = vjj_ff;
      jd_in        = jd_ff;
      t_in         = t_ff;
      prev_in      = prev_ff;
      j_in         = j_ff;
      step_in      = step_ff;
      sweep_in     = sweep_ff;
      flag_in      = flag_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      iss     = 1'b0;
      iss_op  = OP_MUL;
      iss_a   = 64'sd0;
      iss_b   = 64'sd0;
      iss_ret = S_IDLE;

      node_we = 1'b0;
      rhs_we  = 1'b0;
      sub_we  = 1'b0;
      sup_we  = 1'b0;
      inv_we  = 1'b0;
      node_wd = 64'sd0;
      rhs_wd  = 64'sd0;
      sub_wd  = 64'sd0;
      sup_wd  = 64'sd0;
      inv_wd  = 64'sd0;

      pay = put_ff ? (strike_ff - res) : (res - strike_ff);

      if (csr_we) begin
         case (csr_index)
            CSR_TIME_STEPS: ts_in  = csr_wdata;
            CSR_SWEEPS:     swc_in = csr_wdata[11:0];
            default: ;
         endcase
      end

      case (st_ff)
         S_IDLE: begin
            if (start) begin
               spot_in   = q_type'({16'h0, req_data.spot_price, 16'h0});
               strike_in = q_type'({16'h0, req_data.strike_price, 16'h0});
               expiry_in = q_type'({24'h0, req_data.expiry_years, 8'h0});
               vol_in    = q_type'({28'h0, req_data.volatility, 4'h0});
               rate_in   = q_type'({{28{req_data.interest_rate[31]}},
                                    req_data.interest_rate, 4'h0});
               yld_in    = q_type'({{28{req_data.dividend_yield[31]}},
                                    req_data.dividend_yield, 4'h0});
               put_in    = req_data.option_kind;
               flag_in   = 1'b0;
               st_in     = S_DS;
            end
         end
         S_WAIT: begin
            if (ursp.done) st_in = ret_ff;
         end
         // this state loads K / 25 into ds_ff, the full spacing is built next cycle
         S_DS: begin
            drift_in = qsub(rate_ff, yld_ff);
            ds_in    = q_type'({36'h0, ds_prod[64:37]});
            st_in    = S_DT;
         end
         S_DT: begin
            ds_in = q_type'({21'h0, ds_ff[27:0], frac_25(k_rem)});
            if (ts_ff == 16'd0) begin
               dt_in = 64'sd0;
               st_in = S_VAR;
            end else begin
               iss = 1'b1; iss_op = OP_DIVI; iss_a = expiry_ff;
               iss_b = q_type'({48'h0, ts_ff}); iss_ret = S_DTR;
            end
         end
         S_DTR: begin
            dt_in = res;
            st_in = S_VAR;
         end
         S_VAR: begin
            iss = 1'b1; iss_a = vol_ff; iss_b = vol_ff; iss_ret = S_VARR;
         end
         S_VARR: begin
            var_in = res;
            j_in   = '0;
            st_in  = S_PISS;
         end
         // payoff: node price is ds * j
         S_PISS: begin
            iss = 1'b1; iss_a = ds_ff; iss_b = jq; iss_ret = S_PWR;
         end
         S_PWR: begin
            rhs_we  = 1'b1;
            rhs_wd  = pay[63] ? 64'sd0 : pay;
            node_we = 1'b1;
            if (j_ff == J_LAST) begin
               j_in  = '0;
               st_in = S_C0;
            end else begin
               j_in  = IDX_W'(j_ff + 1'b1);
               st_in = S_PISS;
            end
         end
         // bottom row: discount only
         S_C0: begin
            iss = 1'b1; iss_a = rate_ff; iss_b = dt_ff; iss_ret = S_C0B;
         end
         S_C0B: begin
            iss = 1'b1; iss_op = OP_DIVQ; iss_a = Q_ONE;
            iss_b = qadd(Q_ONE, res); iss_ret = S_C0W;
         end
         S_C0W: begin
            inv_we = 1'b1; inv_wd = res;
            sub_we = 1'b1;
            sup_we = 1'b1;
            j_in   = IDX_W'(1);
            st_in  = S_CJJ;
         end
         // interior rows
         S_CJJ: begin
            iss = 1'b1; iss_a = jq; iss_b = jq; iss_ret = S_CV;
         end
         S_CV: begin
            iss = 1'b1; iss_a = var_ff; iss_b = res; iss_ret = S_CJD;
         end
         S_CJD: begin
            vjj_in = res;
            iss = 1'b1; iss_a = drift_ff; iss_b = jq; iss_ret = S_CA;
         end
         S_CA: begin
            jd_in = res;
            iss = 1'b1; iss_a = Q_HALF; iss_b = qsub(vjj_ff, res); iss_ret = S_CA2;
         end
         S_CA2: begin
            iss = 1'b1; iss_a = res; iss_b = dt_ff; iss_ret = S_CA3;
         end
         S_CA3: begin
            sub_we = 1'b1; sub_wd = qsub(64'sd0, res);
            iss = 1'b1; iss_a = Q_HALF; iss_b = qadd(vjj_ff, jd_ff); iss_ret = S_CB2;
         end
         S_CB2: begin
            iss = 1'b1; iss_a = res; iss_b = dt_ff; iss_ret = S_CB3;
         end
         S_CB3: begin
            sup_we = 1'b1; sup_wd = qsub(64'sd0, res);
            iss = 1'b1; iss_a = qadd(rate_ff, vjj_ff); iss_b = dt_ff; iss_ret = S_CC2;
         end
         S_CC2: begin
            iss = 1'b1; iss_op = OP_DIVQ; iss_a = Q_ONE;
            iss_b = qadd(Q_ONE, res); iss_ret = S_CC3;
         end
         S_CC3: begin
            inv_we = 1'b1; inv_wd = res;
            if (j_ff == J_PEN) begin
               j_in  = J_LAST;
               st_in = S_N0;
            end else begin
               j_in  = IDX_W'(j_ff + 1'b1);
               st_in = S_CJJ;
            end
         end
         // top row: linear boundary
         S_N0: begin
            iss = 1'b1; iss_a = drift_ff; iss_b = Q_N; iss_ret = S_NA;
         end
         S_NA: begin
            jd_in = res;
            iss = 1'b1; iss_a = res; iss_b = dt_ff; iss_ret = S_NB;
         end
         S_NB: begin
            sub_we = 1'b1; sub_wd = res;
            sup_we = 1'b1;
            iss = 1'b1; iss_a = qsub(jd_ff, rate_ff); iss_b = dt_ff; iss_ret = S_NC;
         end
         S_NC: begin
            iss = 1'b1; iss_op = OP_DIVQ; iss_a = Q_ONE;
            iss_b = qsub(Q_ONE, res); iss_ret = S_ND;
         end
         S_ND: begin
            inv_we  = 1'b1; inv_wd = res;
            step_in = 16'd0;
            st_in   = S_STEP;
         end
         S_STEP: begin
            j_in     = '0;
            sweep_in = 12'd0;
            prev_in  = 64'sd0;
            if (step_ff == ts_ff) begin
               st_in = S_FTOP;
            end else if (swc_ff == 12'd0) begin
               st_in = S_KF;
            end else begin
               st_in = S_GF;
            end
         end
         // one Gauss-Seidel row; the bottom row has zero off-diagonals stored, the top row a zero super-diagonal
         S_GF: st_in = S_GM1;
         S_GM1: begin
            iss = 1'b1; iss_a = sub_q; iss_b = prev_ff; iss_ret = S_GM2;
         end
         S_GM2: begin
            t_in = qsub(rhs_q, res);
            iss = 1'b1; iss_a = sup_q; iss_b = node_q; iss_ret = S_GM3;
         end
         S_GM3: begin
            iss = 1'b1; iss_a = inv_q; iss_b = qsub(t_ff, res); iss_ret = S_GW;
         end
         S_GW: begin
            node_we = 1'b1; node_wd = res;
            prev_in = res;
            if (j_ff == J_LAST) begin
               j_in    = '0;
               prev_in = 64'sd0;
               if (12'(sweep_ff + 1'b1) == swc_ff) begin
                  st_in = S_KF;
               end else begin
                  sweep_in = 12'(sweep_ff + 1'b1);
                  st_in    = S_GF;
               end
            end else begin
               j_in  = IDX_W'(j_ff + 1'b1);
               st_in = S_GF;
            end
         end
         // solution becomes the next right-hand side
         S_KF: st_in = S_KW;
         S_KW: begin
            rhs_we = 1'b1; rhs_wd = node_q;
            if (j_ff == J_LAST) begin
               step_in = 16'(step_ff + 1'b1);
               st_in   = S_STEP;
            end else begin
               j_in  = IDX_W'(j_ff + 1'b1);
               st_in = S_KF;
            end
         end
         // interpolation at spot
         S_FTOP: begin
            iss = 1'b1; iss_a = ds_ff; iss_b = Q_N; iss_ret = S_FT2;
         end
         S_FT2: begin
            if (spot_ff > res) begin
               flag_in = 1'b1;
               j_in    = J_LAST;
               st_in   = S_FRD;
            end else if (ds_ff == 64'sd0) begin
               j_in  = '0;
               st_in = S_FRD;
            end else begin
               iss = 1'b1; iss_op = OP_DIVI; iss_a = spot_ff; iss_b = ds_ff;
               iss_ret = S_FIDX;
            end
         end
         S_FIDX: begin
            if (res >= q_type'(GRID_N)) begin
               j_in  = J_LAST;
               st_in = S_FRD;
            end else begin
               j_in = res[IDX_W-1:0];
               iss  = 1'b1; iss_a = q_type'({res[31:0], 32'h0}); iss_b = ds_ff;
               iss_ret = S_FREM;
            end
         end
         S_FREM: begin
            iss = 1'b1; iss_op = OP_DIVQ; iss_a = spot_ff - res; iss_b = ds_ff;
            iss_ret = S_FLO;
         end
         S_FLO: begin
            prev_in = res;      // fraction
            t_in    = rhs_q;    // lower node
            j_in    = IDX_W'(j_ff + 1'b1);
            st_in   = S_FHW;
         end
         S_FHW: st_in = S_FHI;
         S_FHI: begin
            iss = 1'b1; iss_a = qsub(rhs_q, t_ff); iss_b = prev_ff; iss_ret = S_FSUM;
         end
         S_FSUM: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.option_value  = to_output(qadd(t_ff, res));
            rsp_data_in.out_of_range  = flag_ff;
            st_in                     = S_IDLE;
         end
         S_FRD: st_in = S_FRD2;
         S_FRD2: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.option_value  = to_output(rhs_q);
            rsp_data_in.out_of_range  = flag_ff;
            st_in                     = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase

      if (iss) begin
         go_in  = 1'b1;
         op_in  = iss_op;
         a_in   = iss_a;
         b_in   = iss_b;
         ret_in = iss_ret;
         st_in  = S_WAIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         go_ff        <= 1'b0;
         ts_ff        <= 16'd2000;
         swc_ff       <= 12'd999;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         go_ff        <= go_in;
         ts_ff        <= ts_in;
         swc_ff       <= swc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff      <= ret_in;
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      spot_ff     <= spot_in;
      strike_ff   <= strike_in;
      expiry_ff   <= expiry_in;
      vol_ff      <= vol_in;
      rate_ff     <= rate_in;
      yld_ff      <= yld_in;
      put_ff      <= put_in;
      ds_ff       <= ds_in;
      dt_ff       <= dt_in;
      drift_ff    <= drift_in;
      var_ff      <= var_in;
      vjj_ff      <= vjj_in;
      jd_ff       <= jd_in;
      t_ff        <= t_in;
      prev_ff     <= prev_in;
      j_ff        <= j_in;
      step_ff     <= step_in;
      sweep_ff    <= sweep_in;
      flag_ff     <= flag_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[j_ff] <= node_wd;
      if (rhs_we)  rhs_mem[j_ff]  <= rhs_wd;
      if (sub_we)  sub_mem[j_ff]  <= sub_wd;
      if (sup_we)  sup_mem[j_ff]  <= sup_wd;
      if (inv_we)  inv_mem[j_ff]  <= inv_wd;
      node_q <= node_mem[node_ra];
      rhs_q  <= rhs_mem[j_ff];
      sub_q  <= sub_mem[j_ff];
      sup_q  <= sup_mem[j_ff];
      inv_q  <= inv_mem[j_ff];
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire

[hw/rtl/ifdp_arith.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ifdp_arith
// Shared multi-cycle Q32.32 unit: rounded saturating multiply from four
// 32x32 partial products, and a bit-serial restoring divider (fractional
// with rounding, or plain integer).
// ----------------------------------------------------------------------------
module ifdp_arith
   import ifdp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  arith_req_type req,
   output arith_rsp_type rsp
);

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_MUL  = 2'd1;
   localparam logic [1:0] U_DIV  = 2'd2;
   localparam logic [1:0] U_FIN  = 2'd3;

   logic [1:0]   st_ff, st_in;
   logic [1:0]   op_ff, op_in;
   logic         neg_ff, neg_in;
   logic         aneg_ff, aneg_in;
   logic         azero_ff, azero_in;
   logic         zdiv_ff, zdiv_in;
   logic [63:0]  ua_ff, ua_in;
   logic [63:0]  ub_ff, ub_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63:0]  prod_ff, prod_in;
   logic [127:0] acc_ff, acc_in;
   logic [127:0] num_ff, num_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  q_ff, q_in;
   logic         ovf_ff, ovf_in;
   q_type        res_ff, res_in;
   logic         done_ff, done_in;

   logic [63:0]  ua_go, ub_go;
   logic [31:0]  pa, pb;
   logic [127:0] addend;
   logic [64:0]  rem_sh;
   logic         qbit;
   logic [128:0] rnd;
   logic [63:0]  mag;
   logic         rup;
   logic [64:0]  q1;

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

   always_comb begin
      st_in    = st_ff;
      op_in    = op_ff;
      neg_in   = neg_ff;
      aneg_in  = aneg_ff;
      azero_in = azero_ff;
      zdiv_in  = zdiv_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      ovf_in   = ovf_ff;
      res_in   = res_ff;
      done_in  = 1'b0;

      ua_go = req.a[63] ? 64'(64'd0 - req.a) : 64'(req.a);
      ub_go = req.b[63] ? 64'(64'd0 - req.b) : 64'(req.b);

      pa = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      pb = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      // weight of the partial product taken in the previous cycle
      if (cnt_ff == 7'd1) begin
         addend = {64'h0, prod_ff};
      end else if (cnt_ff == 7'd4) begin
         addend = {prod_ff, 64'h0};
      end else begin
         addend = {32'h0, prod_ff, 32'h0};
      end

      rem_sh = {rem_ff, num_ff[127]};
      qbit   = (rem_sh >= {1'b0, ub_ff});

      rnd = {1'b0, acc_ff} + 129'(64'h8000_0000);
      rup = (rem_ff >= (ub_ff - rem_ff));
      q1  = {1'b0, q_ff} + 65'(rup);
      mag = q_ff;

      case (st_ff)
         U_IDLE: begin
            if (req.go) begin
               op_in    = req.op;
               neg_in   = req.a[63] ^ req.b[63];
               aneg_in  = req.a[63];
               azero_in = (req.a == 64'sd0);
               zdiv_in  = (req.b == 64'sd0);
               ua_in    = ua_go;
               ub_in    = ub_go;
               cnt_in   = 7'd0;
               acc_in   = 128'h0;
               rem_in   = 64'h0;
               q_in     = 64'h0;
               ovf_in   = 1'b0;
               num_in   = (req.op == OP_DIVQ) ? {32'h0, ua_go, 32'h0} : {64'h0, ua_go};
               if (req.op == OP_MUL) begin
                  st_in = U_MUL;
               end else if (req.b == 64'sd0) begin
                  st_in = U_FIN;
               end else begin
                  st_in = U_DIV;
               end
            end
         end
         U_MUL: begin
            if (cnt_ff != 7'd4) prod_in = pa * pb;
            if (cnt_ff != 7'd0) acc_in = acc_ff + addend;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd4) st_in = U_FIN;
         end
         U_DIV: begin
            rem_in = qbit ? 64'(rem_sh - {1'b0, ub_ff}) : rem_sh[63:0];
            q_in   = {q_ff[62:0], qbit};
            ovf_in = ovf_ff | q_ff[63];
            num_in = {num_ff[126:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) st_in = U_FIN;
         end
         U_FIN: begin
            if (op_ff == OP_MUL) begin
               mag    = (rnd[128:96] != 33'h0) ? '1 : rnd[95:32];
               res_in = make_signed(neg_ff, mag);
            end else if (zdiv_ff) begin
               res_in = aneg_ff ? Q_MIN : (azero_ff ? 64'sd0 : Q_MAX);
            end else if (op_ff == OP_DIVQ) begin
               mag    = (ovf_ff | q1[64]) ? '1 : q1[63:0];
               res_in = make_signed(neg_ff, mag);
            end else begin
               res_in = make_signed(neg_ff, mag);
            end
            done_in = 1'b1;
            st_in   = U_IDLE;
         end
         default: st_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= U_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      neg_ff   <= neg_in;
      aneg_ff  <= aneg_in;
      azero_ff <= azero_in;
      zdiv_ff  <= zdiv_in;
      ua_ff    <= ua_in;
      ub_ff    <= ub_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      ovf_ff   <= ovf_in;
      res_ff   <= res_in;
   end

endmodule
`default_nettype wire
